@@ hdl/sdfsu_pkg.sv @@
// sdfsu_pkg: payload structs, register map and mode codes for the shell union field block
package sdfsu_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned THICK_W = 31;
    localparam int unsigned ADDR_W  = 5;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_SPHERE_RADIUS     = 3'd0;
    localparam logic [2:0] REG_SURFACE_THICKNESS = 3'd1;
    localparam logic [2:0] REG_SHELL_THICKNESS   = 3'd2;
    localparam logic [2:0] REG_TRUNCATE_ENABLE   = 3'd3;
    localparam logic [2:0] REG_FIELD_MODE        = 3'd4;

    localparam logic [1:0] MODE_UNION       = 2'd0;
    localparam logic [1:0] MODE_SURFACE     = 2'd1;
    localparam logic [1:0] MODE_SHELL       = 2'd2;
    localparam logic [1:0] MODE_UNION_CARVE = 2'd3;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] surface_distance;
        logic signed [DATA_W-1:0] offset_x;
        logic signed [DATA_W-1:0] offset_y;
        logic signed [DATA_W-1:0] offset_z;
        logic                     last_voxel;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] field_value;
        logic signed [DATA_W-1:0] running_min;
        logic signed [DATA_W-1:0] running_max;
        logic                     grid_done;
    } t_out_item;

endpackage

@@ hdl/sdf_shell_union_field.sv @@
// sdf_shell_union_field: bit-serial radial distance and surface/sphere shell field combiner
//
//  channel   direction  handshake                  beat
//  input     in         i_in_valid / o_in_stall    t_in_item, one voxel
//  output    out        o_out_valid / i_out_stall  t_out_item, one result per voxel
//  config    in         psel/penable/pwrite        apb write/read, 5 registers at 4*index
//
//  one voxel goes through serial squaring (one multiplier bit of all three offsets per
//  cycle), the radix-4 square root (one root bit per cycle), and the combine and output
//  steps field, mix, select and done before the next accept.
//  the result register frees the input side: a new beat is taken while a result waits.
//  reset (synchronous, active low) clears config to 0 and restarts the running min/max.
//  an output stall holds the finished result in the final step until the slot frees.
module sdf_shell_union_field (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sdfsu_pkg::t_in_item               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sdfsu_pkg::t_out_item              o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdfsu_pkg::ADDR_W-1:0]      paddr,
    input  logic [sdfsu_pkg::DATA_W-1:0]      pwdata,
    output logic [sdfsu_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQR   = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_FIELD = 3'd3;
    localparam logic [2:0] S_MIX   = 3'd4;
    localparam logic [2:0] S_SEL   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // control state
    logic [2:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    logic [30:0] r_radius, r_surf_thick, r_shell_thick;
    logic        r_trunc;
    logic [1:0]  r_mode;
    logic signed [31:0] r_min, n_min, r_max, n_max;

    // datapath
    logic [31:0] r_mx, n_mx, r_my, n_my, r_mz, n_mz;
    logic [31:0] r_bx, n_bx, r_by, n_by, r_bz, n_bz;
    logic [63:0] r_acc, n_acc;
    logic [33:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic signed [31:0] r_dist, n_dist;
    logic        r_last, n_last;
    logic signed [34:0] r_surf, n_surf, r_diff, n_diff, r_shell, n_shell;
    logic signed [31:0] r_value, n_value;
    sdfsu_pkg::t_out_item r_out, n_out;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        in_acc;
    logic [33:0] sq_term;
    logic [35:0] rem_sh, trial;
    logic [30:0] radial;
    logic signed [34:0] dr, neg_shell, uni, val_w;
    logic signed [31:0] min_new, max_new;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            sdfsu_pkg::REG_SPHERE_RADIUS:     prdata = {1'b0, r_radius};
            sdfsu_pkg::REG_SURFACE_THICKNESS: prdata = {1'b0, r_surf_thick};
            sdfsu_pkg::REG_SHELL_THICKNESS:   prdata = {1'b0, r_shell_thick};
            sdfsu_pkg::REG_TRUNCATE_ENABLE:   prdata = {31'd0, r_trunc};
            sdfsu_pkg::REG_FIELD_MODE:        prdata = {30'd0, r_mode};
            default:                          prdata = 32'd0;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // one multiplier bit of each offset per cycle, msb first
    assign sq_term = {2'b00, (r_bx[31] ? r_mx : 32'd0)}
                   + {2'b00, (r_by[31] ? r_my : 32'd0)}
                   + {2'b00, (r_bz[31] ? r_mz : 32'd0)};

    // radix-4 root digit: bring down two radicand bits, try (root << 2) | 1
    assign rem_sh = {r_rem, r_acc[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};

    assign radial    = r_root[31] ? 31'h7FFF_FFFF : r_root[30:0];
    assign dr        = r_diff[34] ? -r_diff : r_diff;
    assign neg_shell = -r_shell;
    assign uni       = (r_surf < r_shell) ? r_surf : r_shell;

    always_comb begin
        case (r_mode)
            sdfsu_pkg::MODE_SURFACE:     val_w = r_surf;
            sdfsu_pkg::MODE_SHELL:       val_w = r_shell;
            sdfsu_pkg::MODE_UNION_CARVE: val_w = (uni > neg_shell) ? uni : neg_shell;
            default:                     val_w = uni;
        endcase
    end

    assign min_new = (r_value < r_min) ? r_value : r_min;
    assign max_new = (r_value > r_max) ? r_value : r_max;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_min       = r_min;
        n_max       = r_max;
        n_mx        = r_mx;
        n_my        = r_my;
        n_mz        = r_mz;
        n_bx        = r_bx;
        n_by        = r_by;
        n_bz        = r_bz;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_root      = r_root;
        n_dist      = r_dist;
        n_last      = r_last;
        n_surf      = r_surf;
        n_diff      = r_diff;
        n_shell     = r_shell;
        n_value     = r_value;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mx    = i_in_data.offset_x[31] ? 32'(-i_in_data.offset_x)
                                                     : 32'(i_in_data.offset_x);
                    n_my    = i_in_data.offset_y[31] ? 32'(-i_in_data.offset_y)
                                                     : 32'(i_in_data.offset_y);
                    n_mz    = i_in_data.offset_z[31] ? 32'(-i_in_data.offset_z)
                                                     : 32'(i_in_data.offset_z);
                    n_bx    = n_mx;
                    n_by    = n_my;
                    n_bz    = n_mz;
                    n_acc   = 64'd0;
                    n_dist  = i_in_data.surface_distance;
                    n_last  = i_in_data.last_voxel;
                    n_cnt   = 5'd0;
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                n_acc = {r_acc[62:0], 1'b0} + {30'd0, sq_term};
                n_bx  = {r_bx[30:0], 1'b0};
                n_by  = {r_by[30:0], 1'b0};
                n_bz  = {r_bz[30:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_rem   = 34'd0;
                    n_root  = 32'd0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                n_acc = {r_acc[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem  = 34'(rem_sh - trial);
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[33:0];
                    n_root = {r_root[30:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_FIELD;
                end
            end
            S_FIELD: begin
                n_surf  = 35'(r_dist) - $signed({5'd0, r_surf_thick[30:1]});
                n_diff  = $signed({4'd0, radial}) - $signed({4'd0, r_radius});
                n_state = S_MIX;
            end
            S_MIX: begin
                n_shell = dr - $signed({5'd0, r_shell_thick[30:1]});
                if (r_trunc && (r_diff > r_surf)) begin
                    n_surf = r_diff;
                end
                n_state = S_SEL;
            end
            S_SEL: begin
                if (val_w > 35'(sdfsu_pkg::S32_MAX)) begin
                    n_value = sdfsu_pkg::S32_MAX;
                end else if (val_w < 35'(sdfsu_pkg::S32_MIN)) begin
                    n_value = sdfsu_pkg::S32_MIN;
                end else begin
                    n_value = val_w[31:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.field_value = r_value;
                    n_out.running_min = min_new;
                    n_out.running_max = max_new;
                    n_out.grid_done   = r_last;
                    n_out_valid       = 1'b1;
                    // a grid's last voxel restarts the extremes
                    n_min   = r_last ? sdfsu_pkg::S32_MAX : min_new;
                    n_max   = r_last ? sdfsu_pkg::S32_MIN : max_new;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= 5'd0;
            r_out_valid   <= 1'b0;
            r_min         <= sdfsu_pkg::S32_MAX;
            r_max         <= sdfsu_pkg::S32_MIN;
            r_radius      <= 31'd0;
            r_surf_thick  <= 31'd0;
            r_shell_thick <= 31'd0;
            r_trunc       <= 1'b0;
            r_mode        <= sdfsu_pkg::MODE_UNION;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_min       <= n_min;
            r_max       <= n_max;
            if (cfg_wr) begin
                case (cfg_idx)
                    sdfsu_pkg::REG_SPHERE_RADIUS:     r_radius      <= pwdata[30:0];
                    sdfsu_pkg::REG_SURFACE_THICKNESS: r_surf_thick  <= pwdata[30:0];
                    sdfsu_pkg::REG_SHELL_THICKNESS:   r_shell_thick <= pwdata[30:0];
                    sdfsu_pkg::REG_TRUNCATE_ENABLE:   r_trunc       <= pwdata[0];
                    sdfsu_pkg::REG_FIELD_MODE:        r_mode        <= pwdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_mz    <= n_mz;
        r_bx    <= n_bx;
        r_by    <= n_by;
        r_bz    <= n_bz;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_dist  <= n_dist;
        r_last  <= n_last;
        r_surf  <= n_surf;
        r_diff  <= n_diff;
        r_shell <= n_shell;
        r_value <= n_value;
        r_out   <= n_out;
    end

    a_minmax_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.running_min <= o_out_data.running_max))
        else $error("running min above running max");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.field_value >= o_out_data.running_min &&
                         o_out_data.field_value <= o_out_data.running_max))
        else $error("field value outside running range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SQR && r_cnt == 5'd0))
        else $error("accepted beat did not start squaring");

    a_root_follows_sqr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR && r_cnt == 5'd31) |=> (r_state == S_ROOT && r_root == 32'd0))
        else $error("square root did not start clean");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not loaded into empty slot");

endmodule

@@ tb/tb_top.sv @@
// tb_top: randomized self-checking testbench for the sdf shell union field block
`timescale 1ns / 100ps

module tb_top;

    // expected voxel results, worked out from a private copy of the registers and grid state
    class field_checker;
        logic [30:0]              radius;
        logic [30:0]              surf_thick;
        logic [30:0]              shell_thick;
        logic                     trunc_on;
        logic [1:0]               mode;
        logic signed [31:0]       grid_lo;
        logic signed [31:0]       grid_hi;
        // newest beat at the front, oldest taken from the back
        sdfsu_pkg::t_out_item     expected_fields[$];
        int                       mismatches;

        function new();
            radius      = '0;
            surf_thick  = '0;
            shell_thick = '0;
            trunc_on    = 1'b0;
            mode        = sdfsu_pkg::MODE_UNION;
            grid_lo     = sdfsu_pkg::S32_MAX;
            grid_hi     = sdfsu_pkg::S32_MIN;
            mismatches  = 0;
        endfunction

        task report(string msg);
            if (mismatches < 100) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
            mismatches++;
        endtask

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                sdfsu_pkg::REG_SPHERE_RADIUS:     radius      = value[30:0];
                sdfsu_pkg::REG_SURFACE_THICKNESS: surf_thick  = value[30:0];
                sdfsu_pkg::REG_SHELL_THICKNESS:   shell_thick = value[30:0];
                sdfsu_pkg::REG_TRUNCATE_ENABLE:   trunc_on    = value[0];
                sdfsu_pkg::REG_FIELD_MODE:        mode        = value[1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                sdfsu_pkg::REG_SPHERE_RADIUS:     return {1'b0, radius};
                sdfsu_pkg::REG_SURFACE_THICKNESS: return {1'b0, surf_thick};
                sdfsu_pkg::REG_SHELL_THICKNESS:   return {1'b0, shell_thick};
                sdfsu_pkg::REG_TRUNCATE_ENABLE:   return {31'd0, trunc_on};
                sdfsu_pkg::REG_FIELD_MODE:        return {30'd0, mode};
                default:                          return '0;
            endcase
        endfunction

        function sdfsu_pkg::t_out_item predict_field(sdfsu_pkg::t_in_item v);
            longint    ox, oy, oz;
            longint    radial, rad, surf, shell, dr, val;
            logic [63:0] sum, root, trial;
            sdfsu_pkg::t_out_item r;
            ox  = v.offset_x;
            oy  = v.offset_y;
            oz  = v.offset_z;
            sum = ox * ox + oy * oy + oz * oz;
            // floor square root, one root bit per pass
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sum) root = trial;
            end
            if (root > 64'h7FFF_FFFF) root = 64'h7FFF_FFFF;
            radial = root;
            rad    = radius;
            surf   = v.surface_distance;
            surf   = surf - longint'(surf_thick >> 1);
            if (trunc_on && (radial - rad > surf)) surf = radial - rad;
            dr = radial - rad;
            if (dr < 0) dr = -dr;
            shell = dr - longint'(shell_thick >> 1);
            val = (surf < shell) ? surf : shell;
            case (mode)
                sdfsu_pkg::MODE_SURFACE:     val = surf;
                sdfsu_pkg::MODE_SHELL:       val = shell;
                sdfsu_pkg::MODE_UNION_CARVE: if (-shell > val) val = -shell;
                default: ;
            endcase
            if (val > longint'(sdfsu_pkg::S32_MAX)) val = sdfsu_pkg::S32_MAX;
            if (val < longint'(sdfsu_pkg::S32_MIN)) val = sdfsu_pkg::S32_MIN;
            r.field_value = val[31:0];
            if (r.field_value < grid_lo) grid_lo = r.field_value;
            if (r.field_value > grid_hi) grid_hi = r.field_value;
            r.running_min = grid_lo;
            r.running_max = grid_hi;
            r.grid_done   = v.last_voxel;
            // min and max start over after the last voxel of a grid
            if (v.last_voxel) begin
                grid_lo = sdfsu_pkg::S32_MAX;
                grid_hi = sdfsu_pkg::S32_MIN;
            end
            return r;
        endfunction

        function void note_voxel(sdfsu_pkg::t_in_item v);
            expected_fields.push_front(predict_field(v));
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        task check_field(sdfsu_pkg::t_out_item got);
            sdfsu_pkg::t_out_item want;
            if (expected_fields.size() == 0) begin
                report("result beat with no voxel waiting");
                return;
            end
            want = expected_fields.pop_back();
            if (got.field_value !== want.field_value)
                report($sformatf("field_value got %0d want %0d",
                                 got.field_value, want.field_value));
            if (got.running_min !== want.running_min)
                report($sformatf("running_min got %0d want %0d",
                                 got.running_min, want.running_min));
            if (got.running_max !== want.running_max)
                report($sformatf("running_max got %0d want %0d",
                                 got.running_max, want.running_max));
            if (got.grid_done !== want.grid_done)
                report($sformatf("grid_done got %b want %b", got.grid_done, want.grid_done));
        endtask
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    sdfsu_pkg::t_in_item          i_in_data   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    sdfsu_pkg::t_out_item         o_out_data;
    logic                         psel        = 1'b0;
    logic                         penable     = 1'b0;
    logic                         pwrite      = 1'b0;
    logic [sdfsu_pkg::ADDR_W-1:0] paddr       = '0;
    logic [sdfsu_pkg::DATA_W-1:0] pwdata      = '0;
    logic [sdfsu_pkg::DATA_W-1:0] prdata;
    logic                         pready;

    field_checker tracker = new();

    sdf_shell_union_field u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_field(o_out_data);
    end

    // result side back-pressure: short and long stall runs, now and then a long quiet stretch
    initial begin
        int  len;
        bit  hold;
        forever begin
            hold = ($urandom_range(0, 2) == 0);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 5);
            if ($urandom_range(0, 19) == 0) begin
                hold = 1'b0;
                len  = $urandom_range(200, 600);
            end
            @(negedge i_clk);
            i_out_stall = hold;
            repeat (len - 1) @(negedge i_clk);
        end
    end

    task automatic apb_write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, value);
        // read the register back
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== tracker.reg_value(idx))
            tracker.report($sformatf("register %0d reads %h want %h",
                                     idx, prdata, tracker.reg_value(idx)));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_voxel(input sdfsu_pkg::t_in_item v, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = v;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_voxel(v);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_gap(bit burst);
        int k;
        k = $urandom_range(0, 19);
        if (burst || k < 10) return 0;
        if (k < 18) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 4))
            0, 1: w = w >>> $urandom_range(0, 31);
            2: begin
                case ($urandom_range(0, 4))
                    0:       w = sdfsu_pkg::S32_MIN;
                    1:       w = sdfsu_pkg::S32_MAX;
                    2:       w = '0;
                    3:       w = -32'sd1;
                    default: w = 32'sd1;
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] rand_reg_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom >> $urandom_range(4, 31);
        endcase
    endfunction

    function automatic sdfsu_pkg::t_in_item voxel(logic signed [31:0] d,
                                                  logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z,
                                                  logic last);
        sdfsu_pkg::t_in_item v;
        v.surface_distance = d;
        v.offset_x         = x;
        v.offset_y         = y;
        v.offset_z         = z;
        v.last_voxel       = last;
        return v;
    endfunction

    function automatic sdfsu_pkg::t_in_item make_voxel();
        sdfsu_pkg::t_in_item v;
        v = voxel(rand_word(), rand_word(), rand_word(), rand_word(),
                  $urandom_range(0, 7) == 0);
        // put the voxel near the sphere surface so r - radius changes sign
        if ($urandom_range(0, 3) == 0) begin
            v.offset_x = {1'b0, tracker.radius} + 32'($urandom_range(0, 8)) - 32'd4;
            v.offset_y = $signed(32'($urandom_range(0, 3))) - 32'sd1;
            v.offset_z = '0;
        end
        return v;
    endfunction

    task automatic set_phase(input int p);
        logic [31:0] rad, surf, shell, trunc, fmode;
        case (p)
            0: begin
                rad   = 32'h0005_0000;
                surf  = 32'h0002_0000;
                shell = 32'h0001_0000;
                trunc = 32'd1;
                fmode = {30'd0, sdfsu_pkg::MODE_UNION};
            end
            1: begin
                rad   = '0;
                surf  = '0;
                shell = '0;
                trunc = '0;
                fmode = {30'd0, sdfsu_pkg::MODE_SURFACE};
            end
            2: begin
                rad   = 32'hFFFF_FFFF;
                surf  = 32'hFFFF_FFFF;
                shell = 32'hFFFF_FFFF;
                trunc = 32'd1;
                fmode = {30'd0, sdfsu_pkg::MODE_SHELL};
            end
            3: begin
                rad   = $urandom >> 8;
                surf  = $urandom >> 10;
                shell = $urandom >> 10;
                trunc = '0;
                fmode = {30'd0, sdfsu_pkg::MODE_UNION_CARVE};
            end
            default: begin
                rad   = rand_reg_word();
                surf  = rand_reg_word();
                shell = rand_reg_word();
                trunc = $urandom;
                fmode = $urandom;
            end
        endcase
        apb_write_reg(sdfsu_pkg::REG_SPHERE_RADIUS, rad);
        apb_write_reg(sdfsu_pkg::REG_SURFACE_THICKNESS, surf);
        apb_write_reg(sdfsu_pkg::REG_SHELL_THICKNESS, shell);
        apb_write_reg(sdfsu_pkg::REG_TRUNCATE_ENABLE, trunc);
        apb_write_reg(sdfsu_pkg::REG_FIELD_MODE, fmode);
    endtask

    task automatic send_directed();
        send_voxel(voxel('0, '0, '0, '0, 1'b0), pick_gap(1'b0));
        send_voxel(voxel(sdfsu_pkg::S32_MAX, '0, '0, '0, 1'b0), pick_gap(1'b0));
        send_voxel(voxel(sdfsu_pkg::S32_MIN, '0, '0, '0, 1'b0), pick_gap(1'b0));
        // largest radicand, root saturates
        send_voxel(voxel('0, sdfsu_pkg::S32_MIN, sdfsu_pkg::S32_MIN, sdfsu_pkg::S32_MIN,
                         1'b0), pick_gap(1'b0));
        send_voxel(voxel('0, sdfsu_pkg::S32_MAX, sdfsu_pkg::S32_MAX, sdfsu_pkg::S32_MAX,
                         1'b0), pick_gap(1'b0));
        // exactly on, just inside and just outside the sphere
        send_voxel(voxel('0, 32'sh0005_0000, '0, '0, 1'b0), pick_gap(1'b0));
        send_voxel(voxel('0, '0, -32'sh0005_0000, '0, 1'b0), pick_gap(1'b0));
        send_voxel(voxel('0, '0, '0, 32'sh0005_0001, 1'b0), pick_gap(1'b0));
        send_voxel(voxel(32'sh7FFF_0000, '0, '0, 32'sh0004_FFFF, 1'b0), pick_gap(1'b0));
        send_voxel(voxel('0, 32'sh0003_0000, 32'sh0004_0000, '0, 1'b1), pick_gap(1'b0));
        // two grid ends back to back
        send_voxel(voxel(-32'sd1, 32'sd1, -32'sd1, 32'sd1, 1'b1), pick_gap(1'b0));
        send_voxel(voxel(sdfsu_pkg::S32_MIN, sdfsu_pkg::S32_MAX, sdfsu_pkg::S32_MIN, '0,
                         1'b1), pick_gap(1'b0));
        send_voxel(voxel(32'sh0000_8000, 32'sh0001_0000, 32'sh0001_0000,
                         32'sh0001_0000, 1'b0), pick_gap(1'b0));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int p = 0; p < 10; p++) begin
            set_phase(p);
            if (p == 0) send_directed();
            for (int i = 0; i < 50; i++) begin
                // sender holds off mid-phase until the block has emptied
                if (p == 4 && i == 25) drain_results();
                send_voxel(make_voxel(), pick_gap(p == 5));
            end
            drain_results();
        end
        repeat (100) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
